### design/lobu_pkg.sv
// ----------------------------------------------------------------------------
// lobu_pkg
// shared types and constants of the limit order book unit
// ----------------------------------------------------------------------------
`default_nettype none

package lobu_pkg;

  localparam int OP_W    = 3;
  localparam int ID_W    = 10;
  localparam int PRICE_W = 8;
  localparam int QTY_W   = 16;
  localparam int LC_W    = 7;
  localparam int TOT_W   = 26;
  localparam int CNT_W   = 11;
  localparam int STAT_W  = 3;
  localparam int SPR_W   = 9;

  localparam logic [TOT_W-1:0] TOT_MAX = 26'h3FF_FFFF;
  localparam logic [CNT_W-1:0] CNT_MAX = 11'h7FF;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_UPDATE = 3'd2,
    OP_TOP    = 3'd3,
    OP_DEPTH  = 3'd4,
    OP_LIST   = 3'd5,
    OP_CLEAR  = 3'd6
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 3'd0,
    ST_BAD_PRICE  = 3'd1,
    ST_BAD_QTY    = 3'd2,
    ST_DUPLICATE  = 3'd3,
    ST_NOT_FOUND  = 3'd4,
    ST_WRONG_SIDE = 3'd5
  } status_t;

  typedef struct packed {
    logic               vld;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } order_t;

  typedef struct packed {
    logic [TOT_W-1:0] tot;
    logic [CNT_W-1:0] cnt;
  } level_t;

  typedef enum logic [8:0] {
    S_CLEAR   = 9'b000000001,
    S_IDLE    = 9'b000000010,
    S_ORD     = 9'b000000100,
    S_LVL     = 9'b000001000,
    S_BEST1   = 9'b000010000,
    S_BEST2   = 9'b000100000,
    S_SCAN    = 9'b001000000,
    S_SCAN_RD = 9'b010000000,
    S_EMIT    = 9'b100000000
  } state_t;

endpackage

`default_nettype wire

### design/lobu_ram.sv
// ----------------------------------------------------------------------------
// lobu_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module lobu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### design/limit_order_book_unit.sv
// ----------------------------------------------------------------------------
// limit_order_book_unit
// two-sided limit order book with order table and per-price level tables
// ----------------------------------------------------------------------------
// The input channel (in_valid/in_stall) carries one command per transaction:
// add, remove, update, top query, depth, level listing or clear. The output
// channel (out_valid/out_stall) returns one result per command, or one per
// listed level for a listing, the final one marked by last. Every result
// carries the top of book after the command.
// Timing: a command is taken only while the sequencer is idle. Add, remove
// and update go through the order read, the level read-modify-write, the
// two-stage best-price tree and the output register; a rejected one skips
// the level write, and a top query goes through the best-price tree and
// the output register only. The next command can be taken in the cycle
// after the result is loaded, so commands never overlap. Depth and listing
// walk the price levels from the touch after the tree, one price at a time,
// with an extra level read for each occupied level used. Clear sweeps both
// tables, the larger of ORDER_SLOTS and 2*LVL_N addresses, LVL_N being
// PRICE_LEVELS rounded up to a power of two. Both sides share one level RAM.
// Reset: both tables are swept as for clear, during which in_stall is high;
// level occupancy is cleared at once.
// A result waits in the output register while out_stall is high; the next
// command may already be taken meanwhile. A listing holds its walk while the
// previous level waits.
// ----------------------------------------------------------------------------
`default_nettype none

module limit_order_book_unit #(
  parameter int ORDER_SLOTS  = 1024,
  parameter int PRICE_LEVELS = 256,
  parameter int MAX_LIST     = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [lobu_pkg::OP_W-1:0]          opcode,
  input  wire logic [lobu_pkg::ID_W-1:0]          order_id,
  input  wire logic                               is_buy,
  input  wire logic [lobu_pkg::PRICE_W-1:0]       price,
  input  wire logic [lobu_pkg::QTY_W-1:0]         quantity,
  input  wire logic [lobu_pkg::LC_W-1:0]          level_count,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic        [lobu_pkg::STAT_W-1:0]      status,
  output logic        [lobu_pkg::PRICE_W-1:0]     best_bid,
  output logic        [lobu_pkg::PRICE_W-1:0]     best_ask,
  output logic signed [lobu_pkg::SPR_W-1:0]       spread,
  output logic        [lobu_pkg::TOT_W-1:0]       depth,
  output logic        [lobu_pkg::PRICE_W-1:0]     level_price,
  output logic        [lobu_pkg::TOT_W-1:0]       level_quantity,
  output logic                                    level_valid,
  output logic                                    last
);

  import lobu_pkg::*;

  localparam int OAW    = $clog2(ORDER_SLOTS);
  localparam int LAW    = $clog2(PRICE_LEVELS);
  localparam int LVL_N  = 2 ** LAW;
  localparam int PSPAN  = (PRICE_LEVELS < 256) ? PRICE_LEVELS : 256;
  localparam int NG     = (LVL_N + 15) / 16;
  localparam int OW     = $bits(order_t);
  localparam int LW     = $bits(level_t);
  localparam int CLR_N  = (ORDER_SLOTS > 2 * LVL_N) ? ORDER_SLOTS : 2 * LVL_N;
  localparam int CAW    = $clog2(CLR_N);

  state_t state;

  // latched command
  logic [OP_W-1:0]    op_q;
  logic [ID_W-1:0]    id_q;
  logic               buy_q;
  logic [PRICE_W-1:0] price_q;
  logic [QTY_W-1:0]   qty_q;
  logic [LC_W-1:0]    lc_q;
  status_t            stat_q;

  logic [CAW-1:0]     clr_cnt;
  logic               clr_op;

  logic [LVL_N-1:0]   occ_b, occ_a;

  logic [LAW:0]       lv_addr;
  logic [8:0]         k_q;
  logic [LC_W-1:0]    used_q;
  logic [TOT_W-1:0]   sum_q;
  logic               pend_vld;
  logic [PRICE_W-1:0] pend_price;
  logic [TOT_W-1:0]   pend_qty;

  logic [PRICE_W-1:0] bb_q, ba_q;

  // ram ports
  logic               ord_we, ord_re;
  logic [OAW-1:0]     ord_waddr, ord_raddr;
  order_t             ord_wdata, ord_cur;
  logic [OW-1:0]      ord_rdata;
  logic               lvl_we, lvl_re;
  logic [LAW:0]       lvl_raddr, lvl_waddr;
  level_t             lvl_wdata, lvl_cur;
  logic [LW-1:0]      lvl_rdata;

  lobu_ram #(.WIDTH(OW), .DEPTH(ORDER_SLOTS)) u_ord_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .re    (ord_re),
    .raddr (ord_raddr),
    .rdata (ord_rdata)
  );

  lobu_ram #(.WIDTH(LW), .DEPTH(2 * LVL_N)) u_lvl_ram (
    .clk   (clk),
    .we    (lvl_we),
    .waddr (lvl_waddr),
    .wdata (lvl_wdata),
    .re    (lvl_re),
    .raddr (lvl_raddr),
    .rdata (lvl_rdata)
  );

  logic in_acc, out_free;
  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  logic [LAW-1:0] lv_idx;
  assign lv_idx  = lv_addr[LAW-1:0];
  assign ord_cur = order_t'(ord_rdata);
  assign lvl_cur = level_t'(lvl_rdata);

  // command checks on the order entry just read
  logic    id_ok, price_ok, ord_go;
  status_t ord_stat;
  logic    tgt_side;
  logic [LAW-1:0] tgt_idx;

  assign id_ok    = (32'(id_q) < ORDER_SLOTS);
  assign price_ok = (price_q != '0) && (32'(price_q) < PSPAN);

  always_comb begin
    ord_go   = 1'b0;
    ord_stat = ST_OK;
    tgt_side = buy_q;
    tgt_idx  = LAW'(price_q);
    unique case (op_q) inside
      OP_ADD: begin
        if (!price_ok) ord_stat = ST_BAD_PRICE;
        else if (qty_q == '0) ord_stat = ST_BAD_QTY;
        else if (!id_ok) ord_stat = ST_NOT_FOUND;
        else if (ord_cur.vld) ord_stat = ST_DUPLICATE;
        else ord_go = 1'b1;
      end
      OP_REMOVE, OP_UPDATE: begin
        tgt_side = ord_cur.side;
        tgt_idx  = LAW'(ord_cur.price);
        if (!id_ok || !ord_cur.vld) ord_stat = ST_NOT_FOUND;
        else if (op_q == OP_UPDATE && ord_cur.side != buy_q) ord_stat = ST_WRONG_SIDE;
        else ord_go = 1'b1;
      end
      default: ord_go = 1'b0;
    endcase
  end

  // level update arithmetic
  logic [TOT_W-1:0] lvl_base;
  logic [TOT_W:0]   lvl_add;
  logic [TOT_W-1:0] lvl_sat;
  logic [CNT_W-1:0] cnt_dec;

  always_comb begin
    if (op_q == OP_ADD) begin
      lvl_base = lvl_cur.tot;
    end else if (lvl_cur.tot > TOT_W'(ord_cur.qty)) begin
      lvl_base = lvl_cur.tot - TOT_W'(ord_cur.qty);
    end else begin
      lvl_base = '0;
    end
    lvl_add = {1'b0, lvl_base} + (TOT_W + 1)'(qty_q);
    lvl_sat = (lvl_add > {1'b0, TOT_MAX}) ? TOT_MAX : lvl_add[TOT_W-1:0];
    cnt_dec = (lvl_cur.cnt != '0) ? lvl_cur.cnt - 1'b1 : '0;
    lvl_wdata = lvl_cur;
    ord_wdata = '0;
    unique case (op_q)
      OP_ADD: begin
        lvl_wdata.tot = lvl_sat;
        lvl_wdata.cnt = (lvl_cur.cnt < CNT_MAX) ? lvl_cur.cnt + 1'b1 : lvl_cur.cnt;
        ord_wdata     = '{vld: 1'b1, side: buy_q, price: price_q, qty: qty_q};
      end
      OP_REMOVE: begin
        lvl_wdata.cnt = cnt_dec;
        lvl_wdata.tot = (cnt_dec == '0) ? '0 : lvl_base;
        ord_wdata     = '0;
      end
      OP_UPDATE: begin
        lvl_wdata.tot = lvl_sat;
        ord_wdata     = ord_cur;
        ord_wdata.qty = qty_q;
      end
      default: lvl_wdata = lvl_cur;
    endcase
    if (state == S_CLEAR) begin
      ord_wdata = '0;
      lvl_wdata = '0;
    end
  end

  // price walk from the touch outward
  logic [PRICE_W-1:0] walk_p;
  logic [LAW-1:0]     walk_idx;
  logic               walk_occ, scan_done;
  logic [LC_W-1:0]    lc1, lim;

  assign walk_p   = buy_q ? PRICE_W'(PSPAN - 1) - k_q[PRICE_W-1:0] : k_q[PRICE_W-1:0];
  assign walk_idx = LAW'(walk_p);
  assign walk_occ = (buy_q ? occ_b[walk_idx] : occ_a[walk_idx]) && (walk_p != '0);
  assign lc1      = (lc_q == '0) ? LC_W'(1) : lc_q;
  assign lim      = (op_q == OP_LIST && lc1 > LC_W'(MAX_LIST)) ? LC_W'(MAX_LIST) : lc1;
  assign scan_done = (k_q == 9'(PSPAN)) || (used_q == lim);

  logic [TOT_W:0] sum_add;
  assign sum_add = {1'b0, sum_q} + {1'b0, lvl_cur.tot};

  // ram control, the clear sweep covers both tables
  logic clr_ord, clr_lvl;
  assign clr_ord = (state == S_CLEAR) && (32'(clr_cnt) < ORDER_SLOTS);
  assign clr_lvl = (state == S_CLEAR) && (32'(clr_cnt) < 2 * LVL_N);

  always_comb begin
    ord_re    = (state == S_IDLE) && in_acc;
    ord_raddr = OAW'(order_id);
    ord_we    = clr_ord || (state == S_LVL);
    ord_waddr = (state == S_CLEAR) ? OAW'(clr_cnt) : OAW'(id_q);
    lvl_we    = clr_lvl || (state == S_LVL);
    lvl_waddr = (state == S_CLEAR) ? (LAW + 1)'(clr_cnt) : lv_addr;
    lvl_re    = 1'b0;
    lvl_raddr = {tgt_side, tgt_idx};
    if (state == S_ORD) begin
      lvl_re = ord_go;
    end else if (state == S_SCAN) begin
      lvl_re    = !scan_done && walk_occ;
      lvl_raddr = {buy_q, walk_idx};
    end
  end

  // best price tree, group stage then combine stage
  logic [NG*16-1:0] occ_b_pad, occ_a_pad;
  logic [NG-1:0]    gb_any, ga_any, gb_any_q, ga_any_q;
  logic [3:0]       gb_hi [NG];
  logic [3:0]       ga_lo [NG];
  logic [3:0]       gb_hi_q [NG];
  logic [3:0]       ga_lo_q [NG];
  logic [PRICE_W-1:0] bb_next, ba_next;

  assign occ_b_pad = (NG * 16)'(occ_b);
  assign occ_a_pad = (NG * 16)'(occ_a);

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      gb_any[g] = |occ_b_pad[g*16 +: 16];
      ga_any[g] = |occ_a_pad[g*16 +: 16];
      gb_hi[g]  = '0;
      ga_lo[g]  = '0;
      for (int i = 0; i < 16; i++) begin
        if (occ_b_pad[g*16 + i]) gb_hi[g] = 4'(i);
      end
      for (int i = 15; i >= 0; i--) begin
        if (occ_a_pad[g*16 + i]) ga_lo[g] = 4'(i);
      end
    end
  end

  always_comb begin
    bb_next = '0;
    ba_next = '0;
    for (int g = 0; g < NG; g++) begin
      if (gb_any_q[g]) bb_next = PRICE_W'(g * 16 + int'(gb_hi_q[g]));
    end
    for (int g = NG - 1; g >= 0; g--) begin
      if (ga_any_q[g]) ba_next = PRICE_W'(g * 16 + int'(ga_lo_q[g]));
    end
  end

  always_ff @(posedge clk) begin
    gb_any_q <= gb_any;
    ga_any_q <= ga_any;
    gb_hi_q  <= gb_hi;
    ga_lo_q  <= ga_lo;
  end

  logic signed [SPR_W-1:0] spread_cur;
  assign spread_cur = (bb_q != '0 && ba_q != '0) ?
                      SPR_W'({1'b0, ba_q} - {1'b0, bb_q}) : '0;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_cnt  <= '0;
      clr_op   <= 1'b0;
      occ_b    <= '0;
      occ_a    <= '0;
      pend_vld <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CAW'(CLR_N - 1)) begin
            clr_cnt <= '0;
            state   <= clr_op ? S_BEST1 : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            op_q     <= opcode;
            id_q     <= order_id;
            buy_q    <= is_buy;
            price_q  <= price;
            qty_q    <= quantity;
            lc_q     <= level_count;
            stat_q   <= ST_OK;
            k_q      <= '0;
            used_q   <= '0;
            sum_q    <= '0;
            pend_vld <= 1'b0;
            case (opcode) inside
              OP_ADD, OP_REMOVE, OP_UPDATE: state <= S_ORD;
              OP_CLEAR: begin
                occ_b  <= '0;
                occ_a  <= '0;
                clr_op <= 1'b1;
                state  <= S_CLEAR;
              end
              default: state <= S_BEST1;
            endcase
          end
        end
        S_ORD: begin
          stat_q  <= ord_stat;
          lv_addr <= {tgt_side, tgt_idx};
          state   <= ord_go ? S_LVL : S_BEST1;
        end
        S_LVL: begin
          if (lv_addr[LAW]) begin
            occ_b[lv_idx] <= (lvl_wdata.cnt != '0);
          end else begin
            occ_a[lv_idx] <= (lvl_wdata.cnt != '0);
          end
          state <= S_BEST1;
        end
        S_BEST1: begin
          clr_op <= 1'b0;
          state  <= S_BEST2;
        end
        S_BEST2: begin
          bb_q  <= bb_next;
          ba_q  <= ba_next;
          state <= (op_q == OP_DEPTH || op_q == OP_LIST) ? S_SCAN : S_EMIT;
        end
        S_SCAN: begin
          if (scan_done) begin
            state <= S_EMIT;
          end else begin
            k_q <= k_q + 1'b1;
            if (walk_occ) begin
              lv_addr <= {buy_q, walk_idx};
              state   <= S_SCAN_RD;
            end
          end
        end
        S_SCAN_RD: begin
          if (op_q == OP_DEPTH) begin
            sum_q  <= (sum_add > {1'b0, TOT_MAX}) ? TOT_MAX : sum_add[TOT_W-1:0];
            used_q <= used_q + 1'b1;
            state  <= S_SCAN;
          end else if (!pend_vld || out_free) begin
            // hold one level back so the final one can carry last
            pend_vld   <= 1'b1;
            pend_price <= PRICE_W'(lv_idx);
            pend_qty   <= lvl_cur.tot;
            used_q     <= used_q + 1'b1;
            state      <= S_SCAN;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_SCAN_RD && op_q == OP_LIST && pend_vld && out_free) begin
      out_valid      <= 1'b1;
      status         <= ST_OK;
      best_bid       <= bb_q;
      best_ask       <= ba_q;
      spread         <= spread_cur;
      depth          <= '0;
      level_price    <= pend_price;
      level_quantity <= pend_qty;
      level_valid    <= 1'b1;
      last           <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_valid      <= 1'b1;
      status         <= stat_q;
      best_bid       <= bb_q;
      best_ask       <= ba_q;
      spread         <= spread_cur;
      depth          <= (op_q == OP_DEPTH) ? sum_q : '0;
      level_price    <= pend_vld ? pend_price : '0;
      level_quantity <= pend_vld ? pend_qty : '0;
      level_valid    <= pend_vld;
      last           <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### design/lobu_checker.sv
// ----------------------------------------------------------------------------
// lobu_props
// port-level assertions for the limit order book unit
// ----------------------------------------------------------------------------
`default_nettype none

module lobu_props (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               in_valid,
  input wire logic                               in_stall,
  input wire logic                               out_valid,
  input wire logic                               out_stall,
  input wire logic        [lobu_pkg::STAT_W-1:0] status,
  input wire logic        [lobu_pkg::PRICE_W-1:0] best_bid,
  input wire logic        [lobu_pkg::PRICE_W-1:0] best_ask,
  input wire logic signed [lobu_pkg::SPR_W-1:0]  spread,
  input wire logic        [lobu_pkg::PRICE_W-1:0] level_price,
  input wire logic        [lobu_pkg::TOT_W-1:0]  level_quantity,
  input wire logic                               level_valid,
  input wire logic                               last
);

  import lobu_pkg::*;

  // table sweep keeps the input closed right after reset
  a_reset_sweep: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input open right after reset");

  // one command at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(last))
    else $error("stalled result changed");

  a_spread: assert property (@(posedge clk) disable iff (rst)
    out_valid && (best_bid == '0 || best_ask == '0) |-> spread == '0)
    else $error("spread with an empty side");

  a_plain: assert property (@(posedge clk) disable iff (rst)
    out_valid && !level_valid |-> level_price == '0 && level_quantity == '0 && last)
    else $error("non-level result carries level data");

endmodule

bind limit_order_book_unit lobu_props u_lobu_props (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .status         (status),
  .best_bid       (best_bid),
  .best_ask       (best_ask),
  .spread         (spread),
  .level_price    (level_price),
  .level_quantity (level_quantity),
  .level_valid    (level_valid),
  .last           (last)
);

`default_nettype wire
